// ===== src/lfr_pkg.sv =====
`timescale 1ns / 1ps

package lfr_pkg;

	// Widths of the item and result fields at the ports.
	localparam int FRAME_W = 6;
	localparam int COUNT_W = 7;
	localparam int OP_W    = 2;

	// Operation codes carried by an input item.
	typedef enum logic [OP_W-1:0] {
		OP_PIN    = 2'd0,
		OP_UNPIN  = 2'd1,
		OP_VICTIM = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic exec;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
	} ctrl_sts_t;

endpackage

// ===== src/lfr_datapath.sv =====
`timescale 1ns / 1ps

module lfr_datapath #(
	parameter int NUM_FRAMES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lfr_pkg::ctrl_cmd_t              cmd,
	output lfr_pkg::ctrl_sts_t              sts,
	input  logic [lfr_pkg::OP_W-1:0]        opcode,
	input  logic [lfr_pkg::FRAME_W-1:0]     frame_number,
	output logic                            victim_found,
	output logic [lfr_pkg::FRAME_W-1:0]     victim_frame,
	output logic [lfr_pkg::COUNT_W-1:0]     listed_count
);
	import lfr_pkg::*;

	localparam int FW = $clog2(NUM_FRAMES);
	localparam int CW = $clog2(NUM_FRAMES + 1);

	// Per-frame stores: listed flag and the two list links.
	logic          flag_mem  [NUM_FRAMES];
	logic [FW-1:0] newer_mem [NUM_FRAMES];
	logic [FW-1:0] older_mem [NUM_FRAMES];

	// List head, tail and size.
	logic [FW-1:0] newest_q, newest_d;
	logic [FW-1:0] oldest_q, oldest_d;
	logic [CW-1:0] count_q, count_d;

	// Clearing pass address.
	logic [FW-1:0] clr_q;

	// Captured item and registered memory reads.
	op_t           op_q;
	logic [FW-1:0] tgt_q;
	logic          in_range_q;
	logic          flag_rd_q;
	logic [FW-1:0] newer_rd_q;
	logic [FW-1:0] older_rd_q;

	// Result registers.
	logic          found_q;
	logic [FW-1:0] vframe_q;

	// Input frame mapped into the index space.
	logic [31:0]   frame_ext;
	logic [FW-1:0] frame_idx;
	logic          in_range;
	logic [FW-1:0] rd_addr;

	// Execute-cycle decisions and memory write ports.
	logic          do_unlink, do_push, found;
	logic          flag_we, flag_wd;
	logic [FW-1:0] flag_wa;
	logic          newer_we, older_we;
	logic [FW-1:0] newer_wa, newer_wd, older_wa, older_wd;

	logic [31:0]   vframe_ext;
	logic [31:0]   count_ext;

	assign frame_ext = 32'(frame_number);
	assign frame_idx = frame_ext[FW-1:0];
	assign in_range  = frame_ext < 32'(NUM_FRAMES);

	// A victim request reads the oldest frame, pin and unpin read the named frame.
	assign rd_addr = (op_t'(opcode) == OP_VICTIM) ? oldest_q : frame_idx;

	assign sts.clear_last = (clr_q == FW'(NUM_FRAMES - 1));

	// Capture the item and read its frame's flag and links.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= op_t'(opcode);
			tgt_q      <= rd_addr;
			in_range_q <= in_range;
			flag_rd_q  <= flag_mem[rd_addr];
			newer_rd_q <= newer_mem[rd_addr];
			older_rd_q <= older_mem[rd_addr];
		end
	end

	// Decide the list update for the captured item.
	always_comb begin
		do_unlink = 1'b0;
		do_push   = 1'b0;
		found     = 1'b0;
		unique case (op_q)
			OP_PIN: begin
				do_unlink = in_range_q & flag_rd_q;
			end
			OP_UNPIN: begin
				do_push = in_range_q & ~flag_rd_q;
			end
			OP_VICTIM: begin
				do_unlink = (count_q != '0);
				found     = (count_q != '0);
			end
			default: begin
			end
		endcase
	end

	// Next list state and memory writes for the clearing pass and the execute cycle.
	always_comb begin
		newest_d = newest_q;
		oldest_d = oldest_q;
		count_d  = count_q;
		flag_we  = 1'b0;
		flag_wa  = tgt_q;
		flag_wd  = 1'b0;
		newer_we = 1'b0;
		newer_wa = older_rd_q;
		newer_wd = newer_rd_q;
		older_we = 1'b0;
		older_wa = newer_rd_q;
		older_wd = older_rd_q;
		if (cmd.clear) begin
			flag_we = 1'b1;
			flag_wa = clr_q;
			flag_wd = 1'b0;
		end else if (cmd.exec && do_unlink) begin
			flag_we = 1'b1;
			flag_wd = 1'b0;
			if (count_q <= CW'(1)) begin
				count_d = '0;
			end else begin
				count_d = count_q - CW'(1);
				if (tgt_q == newest_q) begin
					newest_d = older_rd_q;
				end else if (tgt_q == oldest_q) begin
					oldest_d = newer_rd_q;
				end else begin
					// Middle of the list: join the two neighbors.
					older_we = 1'b1;
					newer_we = 1'b1;
				end
			end
		end else if (cmd.exec && do_push) begin
			flag_we  = 1'b1;
			flag_wd  = 1'b1;
			newest_d = tgt_q;
			count_d  = count_q + CW'(1);
			if (count_q == '0) begin
				oldest_d = tgt_q;
			end else begin
				newer_we = 1'b1;
				newer_wa = newest_q;
				newer_wd = tgt_q;
				older_we = 1'b1;
				older_wa = tgt_q;
				older_wd = newest_q;
			end
		end
	end

	// Memory write ports.
	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (newer_we) begin
			newer_mem[newer_wa] <= newer_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (older_we) begin
			older_mem[older_wa] <= older_wd;
		end
	end

	// List state and clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			oldest_q <= '0;
			count_q  <= '0;
			clr_q    <= '0;
		end else begin
			newest_q <= newest_d;
			oldest_q <= oldest_d;
			count_q  <= count_d;
			if (cmd.clear) begin
				clr_q <= clr_q + FW'(1);
			end
		end
	end

	// Result of the executed item.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			found_q  <= found;
			vframe_q <= found ? tgt_q : '0;
		end
	end

	assign vframe_ext   = 32'(vframe_q);
	assign count_ext    = 32'(count_q);
	assign victim_found = found_q;
	assign victim_frame = vframe_ext[FRAME_W-1:0];
	assign listed_count = count_ext[COUNT_W-1:0];

endmodule

// ===== src/lfr_ctrl.sv =====
`timescale 1ns / 1ps

module lfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lfr_pkg::ctrl_sts_t sts,
	output lfr_pkg::ctrl_cmd_t cmd,
	output logic               busy,
	output logic               done
);
	import lfr_pkg::*;

	state_t state_q, state_d;
	logic   done_q;

	// State register and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd.clear = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		busy      = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

// ===== src/lru_frame_replacer.sv =====
`timescale 1ns / 1ps

// LRU replacement list for NUM_FRAMES buffer frames. An item (opcode, frame_number)
// is taken when start is high and busy is low: pin removes a listed frame, unpin
// appends an unlisted frame at the newest end, victim removes and returns the oldest
// frame. Every item gives one result, shown for exactly one cycle with done high;
// the receiver cannot hold it, so it must capture the result in that cycle. An item
// is loaded, reading the frame's flag and links from the synchronous per-frame
// memories, then executed, writing the neighbors' links. The result appears in the
// cycle after execution, and busy is already low then, so a new item can be
// taken while the result is shown, but not while one executes. After reset the
// block clears the listed flags, one frame a cycle, keeping busy high meanwhile.
module lru_frame_replacer #(
	parameter int NUM_FRAMES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [lfr_pkg::OP_W-1:0]    opcode,
	input  logic [lfr_pkg::FRAME_W-1:0] frame_number,
	output logic                        done,
	output logic                        victim_found,
	output logic [lfr_pkg::FRAME_W-1:0] victim_frame,
	output logic [lfr_pkg::COUNT_W-1:0] listed_count
);
	import lfr_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// Sequencer.
	lfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// List memories and update logic.
	lfr_datapath #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.frame_number (frame_number),
		.victim_found (victim_found),
		.victim_frame (victim_frame),
		.listed_count (listed_count)
	);

endmodule

// ===== tb/tb_lru_frame_replacer.sv =====
`timescale 1ns / 1ps

module tb_lru_frame_replacer;

	import lfr_pkg::*;

	localparam int NUM_FRAMES = 64;

	// One pending operation with the sender gap odds that apply before it.
	typedef struct {
		op_t              op;
		logic [FRAME_W-1:0] frame;
		int unsigned      gap_pct;
		bit               drain;
	} frame_op_t;

	// What one operation should report.
	typedef struct {
		logic               found;
		logic [FRAME_W-1:0] frame;
		logic [COUNT_W-1:0] count;
	} replace_result_t;

	// Operation mixes used by the random part.
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN,
		MIX_HOT
	} mix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	op_t                opcode = OP_PIN;
	logic [FRAME_W-1:0] frame_number = '0;
	logic               busy;
	logic               done;
	logic               victim_found;
	logic [FRAME_W-1:0] victim_frame;
	logic [COUNT_W-1:0] listed_count;

	frame_op_t       pending_ops[$];
	replace_result_t expected_results[$];
	frame_op_t       next_op;
	replace_result_t oldest_expected;
	int unsigned     mismatch_count = 0;

	// Shadow copy of the recency list.
	bit                 on_list[NUM_FRAMES];
	logic [FRAME_W-1:0] toward_newer[NUM_FRAMES];
	logic [FRAME_W-1:0] toward_older[NUM_FRAMES];
	logic [FRAME_W-1:0] newest_slot = '0;
	logic [FRAME_W-1:0] oldest_slot = '0;
	logic [COUNT_W-1:0] list_len = '0;

	lru_frame_replacer #(
		.NUM_FRAMES(NUM_FRAMES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.frame_number(frame_number),
		.done(done),
		.victim_found(victim_found),
		.victim_frame(victim_frame),
		.listed_count(listed_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Take a frame out of the shadow list, patching its neighbors.
	function automatic void unlink_shadow(input logic [FRAME_W-1:0] f);
		logic [FRAME_W-1:0] nw;
		logic [FRAME_W-1:0] od;
		if (list_len <= 1) begin
			list_len = '0;
		end else begin
			if (f == newest_slot) begin
				newest_slot = toward_older[f];
			end else if (f == oldest_slot) begin
				oldest_slot = toward_newer[f];
			end else begin
				nw = toward_newer[f];
				od = toward_older[f];
				toward_older[nw] = od;
				toward_newer[od] = nw;
			end
			list_len = list_len - 1'b1;
		end
		on_list[f] = 1'b0;
	endfunction

	// Apply one operation to the shadow list and return what the block should report.
	function automatic replace_result_t apply_lru_op(input op_t op,
		input logic [FRAME_W-1:0] f);
		replace_result_t r;
		r.found = 1'b0;
		r.frame = '0;
		case (op)
		OP_PIN: begin
			if (on_list[f])
				unlink_shadow(f);
		end
		OP_UNPIN: begin
			if (!on_list[f]) begin
				if (list_len == 0) begin
					oldest_slot = f;
				end else begin
					toward_newer[newest_slot] = f;
					toward_older[f] = newest_slot;
				end
				newest_slot = f;
				list_len = list_len + 1'b1;
				on_list[f] = 1'b1;
			end
		end
		OP_VICTIM: begin
			if (list_len != 0) begin
				r.found = 1'b1;
				r.frame = oldest_slot;
				unlink_shadow(oldest_slot);
			end
		end
		default: begin
		end
		endcase
		r.count = list_len;
		return r;
	endfunction

	task automatic add_op(input op_t op, input int f, input int unsigned gap_pct,
		input bit drain);
		frame_op_t item;
		item.op = op;
		item.frame = f[FRAME_W-1:0];
		item.gap_pct = gap_pct;
		item.drain = drain;
		pending_ops.push_back(item);
	endtask

	// Driver: record accepted items, then present the next one or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			opcode <= OP_PIN;
			frame_number <= '0;
		end else begin
			if (start && !busy)
				expected_results.push_back(apply_lru_op(opcode, frame_number));
			if (!start || !busy) begin
				if (pending_ops.size() == 0) begin
					start <= 1'b0;
				end else if (pending_ops[0].drain && expected_results.size() != 0) begin
					start <= 1'b0;
				end else if ($urandom_range(99) < pending_ops[0].gap_pct) begin
					start <= 1'b0;
				end else begin
					next_op = pending_ops.pop_front();
					start <= 1'b1;
					opcode <= next_op.op;
					frame_number <= next_op.frame;
				end
			end
		end
	end

	// Monitor: every strobed result must match the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: result with nothing expected: %s %b frame %0d count %0d",
						$realtime, "found", victim_found, victim_frame,
						listed_count);
				mismatch_count++;
			end else begin
				oldest_expected = expected_results.pop_front();
				if (victim_found !== oldest_expected.found
						|| victim_frame !== oldest_expected.frame
						|| listed_count !== oldest_expected.count) begin
					if (mismatch_count < 10)
						$display({"%0t: expected found %b frame %0d count %0d, ",
							"got found %b frame %0d count %0d"},
							$realtime, oldest_expected.found, oldest_expected.frame,
							oldest_expected.count, victim_found, victim_frame,
							listed_count);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int          n;
		int          roll;
		int          f;
		int          j;
		int          tmp;
		int          perm[NUM_FRAMES];
		int unsigned gap;
		mix_t        mix;
		op_t         op;
		int unsigned idle_by_phase[4];

		idle_by_phase[0] = 0;
		idle_by_phase[1] = 78;
		idle_by_phase[2] = 0;
		idle_by_phase[3] = 29;
		mix = MIX_EVEN;

		// Directed: empty victim, pin of an unlisted frame, head, tail and middle removal,
		// repeated unpin, the unused opcode, and a single-entry list.
		add_op(OP_VICTIM, 0, 0, 0);
		add_op(OP_PIN, 0, 0, 0);
		add_op(OP_UNPIN, 0, 0, 0);
		add_op(OP_UNPIN, 63, 0, 0);
		add_op(OP_UNPIN, 21, 0, 0);
		add_op(OP_UNPIN, 42, 0, 0);
		add_op(OP_UNPIN, 63, 0, 0);
		add_op(OP_PIN, 21, 0, 0);
		add_op(OP_PIN, 42, 0, 0);
		add_op(OP_PIN, 0, 0, 0);
		add_op(OP_VICTIM, 0, 0, 0);
		add_op(OP_VICTIM, 63, 0, 0);
		add_op(OP_NOP, 63, 0, 0);
		add_op(OP_UNPIN, 42, 0, 0);
		add_op(OP_NOP, 21, 0, 0);
		add_op(OP_UNPIN, 21, 0, 0);
		add_op(OP_VICTIM, 0, 0, 0);
		add_op(OP_UNPIN, 5, 0, 0);
		add_op(OP_PIN, 5, 0, 0);
		add_op(OP_PIN, 21, 0, 0);
		add_op(OP_VICTIM, 0, 0, 1);

		// Random part in phases of sender idling, with a full-list sweep in the middle.
		n = 0;
		while (n < 600) begin
			gap = idle_by_phase[(n / 150) % 4];
			if (n == 300) begin
				for (int i = 0; i < NUM_FRAMES; i++)
					perm[i] = i;
				for (int i = NUM_FRAMES - 1; i > 0; i--) begin
					j = $urandom_range(i);
					tmp = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				for (int i = 0; i < NUM_FRAMES; i++)
					add_op(OP_UNPIN, perm[i], gap, 0);
				n += NUM_FRAMES;
				mix = MIX_DRAIN;
			end else begin
				if (n % 50 == 0)
					mix = mix_t'($urandom_range(3));
				roll = $urandom_range(99);
				if (roll < 3)
					op = OP_NOP;
				else if (mix == MIX_FILL)
					op = roll < 75 ? OP_UNPIN : (roll < 88 ? OP_PIN : OP_VICTIM);
				else if (mix == MIX_DRAIN)
					op = roll < 25 ? OP_UNPIN : (roll < 55 ? OP_PIN : OP_VICTIM);
				else
					op = roll < 45 ? OP_UNPIN : (roll < 70 ? OP_PIN : OP_VICTIM);
				if (mix == MIX_HOT)
					f = $urandom_range(1) ? $urandom_range(7) : 56 + $urandom_range(7);
				else
					f = $urandom_range(NUM_FRAMES - 1);
				add_op(op, f, gap, n % 97 == 40);
				n++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hard stop if the run hangs.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
